>>> rtl/tpqbs_pkg.sv
// ----------------------------------------------------------------------------
// tpqbs_pkg: shared types and constants of the burst scheduler
// word layouts, status and opcode codes, register indexes and reset values
// ----------------------------------------------------------------------------
package tpqbs_pkg;

	localparam int QUEUE_DEPTH_DEF = 256;
	localparam int HANDLE_W        = 32;
	localparam int OCC_W           = 9;
	localparam int LIMIT_W         = 9;
	localparam int BURST_W         = 8;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 9;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL_RETRY = 2'd1,
		ST_FULL_DROP  = 2'd2,
		ST_NULL       = 2'd3
	} status_t;

	localparam logic OP_PUSH      = 1'b0;
	localparam logic OP_SERVICE   = 1'b1;
	localparam logic CLASS_NORMAL = 1'b0;
	localparam logic CLASS_LOW    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LENGTH_LIMIT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_BURST_LIMIT = 4'd1;

	localparam logic [LIMIT_W-1:0] QUEUE_LENGTH_LIMIT_RST = 9'd0;
	localparam logic [BURST_W-1:0] NORMAL_BURST_LIMIT_RST = 8'd8;

	typedef struct packed {
		logic                opcode;
		logic                push_class;
		logic [HANDLE_W-1:0] packet_handle;
		logic                blocking;
	} item_t;

	typedef struct packed {
		status_t             status;
		logic                served_valid;
		logic [HANDLE_W-1:0] served_handle;
		logic                served_class;
		logic [OCC_W-1:0]    normal_occupancy;
		logic [OCC_W-1:0]    low_occupancy;
	} result_t;

	// per-queue command from the scheduler to a queue
	typedef struct packed {
		logic push;
		logic pop;
	} q_cmd_t;

endpackage

>>> rtl/tpqbs_ram.sv
// ----------------------------------------------------------------------------
// tpqbs_ram: generic single write, single read port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module tpqbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/tpqbs_queue.sv
// ----------------------------------------------------------------------------
// tpqbs_queue: one circular handle queue
// head, tail and fill count around a ram; push and pop never coincide
// ----------------------------------------------------------------------------
module tpqbs_queue #(
	parameter int QUEUE_DEPTH = tpqbs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tpqbs_pkg::q_cmd_t                cmd,
	input  logic [tpqbs_pkg::HANDLE_W-1:0]   wdata,
	output logic [tpqbs_pkg::HANDLE_W-1:0]   rdata,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);
	import tpqbs_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			tail_q  <= (tail_q == LAST) ? '0 : tail_q + 1'b1;
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			head_q  <= (head_q == LAST) ? '0 : head_q + 1'b1;
			count_q <= count_q - 1'b1;
		end
	end

	assign count = count_q;

	tpqbs_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (tail_q),
		.wdata (wdata),
		.re    (cmd.pop),
		.raddr (head_q),
		.rdata (rdata)
	);

endmodule

>>> rtl/two_priority_queue_burst_scheduler_top.sv
// ----------------------------------------------------------------------------
// two_priority_queue_burst_scheduler_top: two-class handle queue scheduler
// normal and low priority handle queues with a burst limit on normal service
// ----------------------------------------------------------------------------
// A command word (push or service request) is taken on every clock edge where
// start is high; busy is never raised, so one word per cycle is sustained.
// Each word gives exactly one result word through the command register and
// the result stage, shown for a single cycle with result_valid high; the
// receiver cannot stall, so it must capture the result in that cycle. The
// result stage lines up with the registered read of the queue ram that
// supplies a served handle. Occupancy figures are those after the
// command. Configuration writes are always accepted (cfg_ready stays high)
// and must only be made while no command is in flight. Queue storage is not
// cleared after reset; only the pointers and counts are.
// ----------------------------------------------------------------------------
module two_priority_queue_burst_scheduler_top #(
	parameter int QUEUE_DEPTH = tpqbs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// command channel
	input  logic                             start,
	output logic                             busy,
	input  tpqbs_pkg::item_t                 item,
	// result strobe
	output logic                             result_valid,
	output tpqbs_pkg::result_t               result,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tpqbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpqbs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tpqbs_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [BURST_W-1:0] BURST_MAX = '1;

	// configuration registers
	logic [LIMIT_W-1:0] len_limit_q;
	logic [BURST_W-1:0] burst_limit_q;

	// command register stage
	logic  valid_s1;
	item_t item_s1;

	// scheduler state
	logic               selected_q;
	logic [BURST_W-1:0] burst_q;

	// queue interfaces
	q_cmd_t             cmd_n;
	q_cmd_t             cmd_l;
	logic [HANDLE_W-1:0] rdata_n;
	logic [HANDLE_W-1:0] rdata_l;
	logic [CNT_W-1:0]    cnt_n;
	logic [CNT_W-1:0]    cnt_l;

	// decisions made in stage one
	status_t             status_c;
	logic                served_c;
	logic                class_c;
	logic                sel_next;
	logic [BURST_W-1:0]  burst_next;
	logic [BURST_W-1:0]  burst_inc;
	logic [CNT_W-1:0]    push_cnt;
	logic [CNT_W-1:0]    sel_cnt;
	logic                refuse;
	logic                had;

	// result stage
	logic    valid_s2;
	status_t status_s2;
	logic    served_s2;
	logic    class_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// register writes; indexes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_limit_q   <= QUEUE_LENGTH_LIMIT_RST;
			burst_limit_q <= NORMAL_BURST_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_QUEUE_LENGTH_LIMIT: len_limit_q   <= LIMIT_W'(cfg_data);
				REG_NORMAL_BURST_LIMIT: burst_limit_q <= BURST_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// capture the command word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// push target: full at capacity, or at the length limit when one is set
	assign push_cnt = item_s1.push_class ? cnt_l : cnt_n;
	assign refuse   = (push_cnt >= FULL_CNT) ||
	                  ((len_limit_q != '0) && (CMP_W'(push_cnt) >= CMP_W'(len_limit_q)));

	// service target is the current selection
	assign sel_cnt   = selected_q ? cnt_l : cnt_n;
	assign had       = (sel_cnt != '0);
	assign burst_inc = (burst_q < BURST_MAX) ? burst_q + 1'b1 : burst_q;

	always_comb begin
		status_c   = ST_OK;
		served_c   = 1'b0;
		class_c    = CLASS_NORMAL;
		sel_next   = selected_q;
		burst_next = burst_q;
		cmd_n      = '0;
		cmd_l      = '0;
		if (valid_s1) begin
			if (item_s1.opcode == OP_PUSH) begin
				if (item_s1.packet_handle == '0) begin
					status_c = ST_NULL;
				end else if (refuse) begin
					status_c = item_s1.blocking ? ST_FULL_RETRY : ST_FULL_DROP;
				end else if (item_s1.push_class == CLASS_LOW) begin
					cmd_l.push = 1'b1;
				end else begin
					cmd_n.push = 1'b1;
				end
			end else begin
				class_c  = selected_q;
				served_c = had;
				if (selected_q == CLASS_LOW) begin
					cmd_l.pop  = had;
					// low service hands the turn back to normal
					sel_next   = CLASS_NORMAL;
					burst_next = '0;
				end else begin
					cmd_n.pop  = had;
					burst_next = burst_inc;
					// empty normal queue or burst used up: give low a turn
					if (!had || burst_inc >= burst_limit_q) begin
						sel_next = CLASS_LOW;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			selected_q <= CLASS_NORMAL;
			burst_q    <= '0;
		end else begin
			selected_q <= sel_next;
			burst_q    <= burst_next;
		end
	end

	tpqbs_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue_normal (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_n),
		.wdata  (item_s1.packet_handle),
		.rdata  (rdata_n),
		.count  (cnt_n)
	);

	tpqbs_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue_low (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_l),
		.wdata  (item_s1.packet_handle),
		.rdata  (rdata_l),
		.count  (cnt_l)
	);

	// result stage lines up with the ram read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		status_s2 <= status_c;
		served_s2 <= served_c;
		class_s2  <= class_c;
	end

	// counts already hold the state after this word, the next word lands later
	assign result_valid            = valid_s2;
	assign result.status           = status_s2;
	assign result.served_valid     = served_s2;
	assign result.served_handle    = !served_s2 ? '0 : (class_s2 ? rdata_l : rdata_n);
	assign result.served_class     = class_s2;
	assign result.normal_occupancy = OCC_W'(cnt_n);
	assign result.low_occupancy    = OCC_W'(cnt_l);

endmodule
